[rtl/mtc_pkg.sv]
// ----------------------------------------------------------------------------
// mtc_pkg
// Shared types, constants and tables of the marching tetrahedra cube block.
// ----------------------------------------------------------------------------
package mtc_pkg;

    localparam int GRID_DIM   = 256;
    localparam int VAL_W      = 16;
    localparam int CRD_W      = 16;
    localparam int FIFO_DEPTH = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ISO    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP   = 2'd2;

    typedef logic signed [CRD_W-1:0] coord_t;
    typedef logic [VAL_W-1:0]        dens_t;

    typedef struct packed {
        logic [15:0]        iso;
        logic signed [14:0] origin;
        logic [13:0]        step;
    } cfg_t;

    // one classified cube: corner positions per axis for offset 0 and 1
    typedef struct packed {
        coord_t [2:0] pos_lo;
        coord_t [2:0] pos_hi;
        dens_t  [7:0] val;
        logic   [7:0] ins;
    } cube_t;

    // one edge to interpolate, from p towards q
    typedef struct packed {
        coord_t [2:0] p_pos;
        coord_t [2:0] q_pos;
        dens_t        va;
        dens_t        vb;
    } edge_req_t;

    // corner i of tetrahedron t; all six share the diagonal 0-6
    function automatic logic [2:0] tet_corner(input logic [2:0] t, input logic [1:0] i);
        logic [11:0] row;
        begin
            case (t)
                3'd0:    row = {3'd6, 3'd1, 3'd5, 3'd0};
                3'd1:    row = {3'd4, 3'd6, 3'd5, 3'd0};
                3'd2:    row = {3'd6, 3'd2, 3'd1, 3'd0};
                3'd3:    row = {3'd6, 3'd3, 3'd2, 3'd0};
                3'd4:    row = {3'd6, 3'd7, 3'd3, 3'd0};
                3'd5:    row = {3'd6, 3'd4, 3'd7, 3'd0};
                default: row = '0;
            endcase
            tet_corner = row[3*i +: 3];
        end
    endfunction

    // unit offset of corner v along axis ax (0 x, 1 y, 2 z)
    function automatic logic corner_bit(input logic [2:0] v, input logic [1:0] ax);
        begin
            case (ax)
                2'd0:    corner_bit = (v == 3'd1) || (v == 3'd2) || (v == 3'd5) || (v == 3'd6);
                2'd1:    corner_bit = (v == 3'd2) || (v == 3'd3) || (v == 3'd6) || (v == 3'd7);
                2'd2:    corner_bit = v[2];
                default: corner_bit = 1'b0;
            endcase
        end
    endfunction

endpackage

[rtl/mtc_front.sv]
// ----------------------------------------------------------------------------
// mtc_front
// Accept cubes, classify corners, compute corner positions, drop off-grid and empty cubes.
// ----------------------------------------------------------------------------
module mtc_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  mtc_pkg::cfg_t              cfg,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [2:0][7:0]            in_idx,
    input  mtc_pkg::dens_t [7:0]       in_val,
    output logic                       push,
    output mtc_pkg::cube_t             push_data,
    input  logic                       full
);
    import mtc_pkg::*;

    localparam logic [10:0] IDX_LIMIT = 11'(GRID_DIM - 2);

    logic               a_valid_reg;
    logic [2:0][21:0]   a_prod_reg;
    dens_t [7:0]        a_val_reg;
    logic [7:0]         a_ins_reg;
    logic               b_valid_reg;
    cube_t              b_data_reg;

    logic               a_adv;
    logic               b_adv;
    logic [7:0]         ins;
    logic               out_grid;
    logic               drop;
    cube_t              b_data_next;

    function automatic coord_t sat16(input logic signed [24:0] v);
        begin
            if (v > 25'sd32767)
                sat16 = 16'sh7fff;
            else if (v < -25'sd32768)
                sat16 = 16'sh8000;
            else
                sat16 = v[15:0];
        end
    endfunction

    assign b_adv    = !b_valid_reg || !full;
    assign a_adv    = !a_valid_reg || b_adv;
    assign in_ready = a_adv;
    assign push     = b_valid_reg && !full;
    assign push_data = b_data_reg;

    always_comb
    begin
        for (int v = 0; v < 8; v++)
        begin
            ins[v] = in_val[v] >= cfg.iso;
        end
        out_grid = 1'b0;
        for (int ax = 0; ax < 3; ax++)
        begin
            if ({3'b000, in_idx[ax]} > IDX_LIMIT)
                out_grid = 1'b1;
        end
        drop = out_grid || (ins == 8'h00) || (ins == 8'hff);
    end

    always_comb
    begin
        logic signed [24:0] lo;
        logic signed [24:0] hi;
        b_data_next = '0;
        for (int ax = 0; ax < 3; ax++)
        begin
            lo = 25'(cfg.origin) + $signed({3'b000, a_prod_reg[ax]});
            hi = lo + $signed({11'd0, cfg.step});
            b_data_next.pos_lo[ax] = sat16(lo);
            b_data_next.pos_hi[ax] = sat16(hi);
        end
        b_data_next.val = a_val_reg;
        b_data_next.ins = a_ins_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_adv)
                a_valid_reg <= in_valid && !drop;
            if (b_adv)
                b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_adv && in_valid)
        begin
            for (int ax = 0; ax < 3; ax++)
            begin
                a_prod_reg[ax] <= in_idx[ax] * cfg.step;
            end
            a_val_reg <= in_val;
            a_ins_reg <= ins;
        end
        if (b_adv)
            b_data_reg <= b_data_next;
    end

endmodule

[rtl/mtc_fifo.sv]
// ----------------------------------------------------------------------------
// mtc_fifo
// Short show-ahead queue of classified cubes between front and back.
// ----------------------------------------------------------------------------
module mtc_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  mtc_pkg::cube_t  push_data,
    input  logic            pop,
    output mtc_pkg::cube_t  head,
    output logic            full,
    output logic            empty
);
    import mtc_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    cube_t              mem [FIFO_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    assign full  = count_reg == CNT_W'(FIFO_DEPTH);
    assign empty = count_reg == '0;
    assign head  = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("cube queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
        else $error("cube queue read while empty");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(FIFO_DEPTH))
        else $error("cube queue count out of range");
`endif

endmodule

[rtl/mtc_edge.sv]
// ----------------------------------------------------------------------------
// mtc_edge
// Edge point unit: clamped interpolation on three axes, one restoring
// divider per axis giving one quotient bit a cycle.
// ----------------------------------------------------------------------------
module mtc_edge (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [15:0]           iso,
    input  mtc_pkg::edge_req_t    req,
    output logic                  busy,
    output mtc_pkg::coord_t [2:0] pt
);
    import mtc_pkg::*;

    typedef enum logic [2:0] {E_IDLE, E_MUL, E_LOAD, E_DIV, E_FIN} state_t;

    state_t             state_reg;
    logic [3:0]         cnt_reg;
    logic [15:0]        num_reg;
    logic [15:0]        den_reg;
    coord_t [2:0]       p_reg;
    logic [2:0]         neg_reg;
    logic [2:0][15:0]   mag_reg;
    logic [2:0][31:0]   prod_reg;
    logic [2:0][16:0]   rem_reg;
    logic [2:0][15:0]   low_reg;
    logic [2:0][15:0]   quo_reg;
    coord_t [2:0]       pt_reg;

    logic signed [16:0] num_s;
    logic signed [16:0] den_s;
    logic signed [16:0] num_f;
    logic signed [16:0] den_f;
    logic               num_pos;
    logic               sel_q;
    logic               sel_p;
    logic [17:0]        dd;

    assign busy = state_reg != E_IDLE;
    assign pt   = pt_reg;
    assign dd   = {1'b0, den_reg, 1'b0};

    always_comb
    begin
        num_s   = $signed({1'b0, iso}) - $signed({1'b0, req.va});
        den_s   = $signed({1'b0, req.vb}) - $signed({1'b0, req.va});
        num_f   = den_s[16] ? -num_s : num_s;
        den_f   = den_s[16] ? -den_s : den_s;
        num_pos = !num_f[16] && (num_f != '0);
        if (den_f == '0)
        begin
            sel_q = num_pos;
            sel_p = !num_pos;
        end
        else
        begin
            sel_q = num_pos && (num_f[15:0] >= den_f[15:0]);
            sel_p = !num_pos;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= E_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                E_IDLE:
                begin
                    if (start && !sel_p && !sel_q)
                        state_reg <= E_MUL;
                end
                E_MUL:  state_reg <= E_LOAD;
                E_LOAD:
                begin
                    state_reg <= E_DIV;
                    cnt_reg   <= '0;
                end
                E_DIV:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == 4'd15)
                        state_reg <= E_FIN;
                end
                E_FIN:  state_reg <= E_IDLE;
                default: state_reg <= E_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        logic [17:0]        rem2;
        logic [33:0]        n;
        logic signed [16:0] d;
        logic signed [16:0] r;
        for (int ax = 0; ax < 3; ax++)
        begin
            case (state_reg)
                E_IDLE:
                begin
                    if (start)
                    begin
                        d = $signed({req.q_pos[ax][15], req.q_pos[ax]})
                            - $signed({req.p_pos[ax][15], req.p_pos[ax]});
                        p_reg[ax]   <= req.p_pos[ax];
                        neg_reg[ax] <= d[16];
                        mag_reg[ax] <= d[16] ? 16'(-d) : d[15:0];
                        if (sel_q)
                            pt_reg[ax] <= req.q_pos[ax];
                        else if (sel_p)
                            pt_reg[ax] <= req.p_pos[ax];
                    end
                end
                E_MUL:  prod_reg[ax] <= mag_reg[ax] * num_reg;
                E_LOAD:
                begin
                    n = {1'b0, prod_reg[ax], 1'b0} + {18'd0, den_reg};
                    rem_reg[ax] <= n[32:16];
                    low_reg[ax] <= n[15:0];
                    quo_reg[ax] <= '0;
                end
                E_DIV:
                begin
                    rem2 = {rem_reg[ax], low_reg[ax][15]};
                    if (rem2 >= dd)
                    begin
                        rem_reg[ax] <= 17'(rem2 - dd);
                        quo_reg[ax] <= {quo_reg[ax][14:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg[ax] <= rem2[16:0];
                        quo_reg[ax] <= {quo_reg[ax][14:0], 1'b0};
                    end
                    low_reg[ax] <= {low_reg[ax][14:0], 1'b0};
                end
                E_FIN:
                begin
                    r = neg_reg[ax] ? -$signed({1'b0, quo_reg[ax]}) : $signed({1'b0, quo_reg[ax]});
                    pt_reg[ax] <= 16'($signed({p_reg[ax][15], p_reg[ax]}) + r);
                end
                default: ;
            endcase
        end
        if (state_reg == E_IDLE && start)
        begin
            num_reg <= num_f[15:0];
            den_reg <= den_f[15:0];
        end
    end

endmodule

[rtl/mtc_back.sv]
// ----------------------------------------------------------------------------
// mtc_back
// Walk the six tetrahedra of the queued cube and emit triangles through
// three mtc_edge units and an output register.
// ----------------------------------------------------------------------------
module mtc_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [15:0]                iso,
    input  mtc_pkg::cube_t             head,
    input  logic                       empty,
    output logic                       pop,
    output logic                       out_valid,
    input  logic                       out_ready,
    output mtc_pkg::coord_t [2:0][2:0] out_vert,
    output logic                       out_last
);
    import mtc_pkg::*;

    typedef enum logic [1:0] {B_IDLE, B_TET, B_WAIT} state_t;

    state_t                 state_reg;
    logic [2:0]             tet_reg;
    logic                   tri_reg;
    logic                   out_valid_reg;
    coord_t [2:0][2:0]      vert_reg;
    logic                   last_reg;

    logic [2:0]             ni;
    logic [2:0]             no;
    logic [3:0][2:0]        ins_l;
    logic [3:0][2:0]        outs_l;
    logic [5:0]             act;
    logic                   later_act;
    logic [2:0][2:0]        p_idx;
    logic [2:0][2:0]        q_idx;
    edge_req_t [2:0]        req;
    logic [2:0]             busy;
    coord_t [2:0][2:0]      pt;
    logic                   start;
    logic                   skip;
    logic                   load;
    logic                   tet_end;

    assign out_valid = out_valid_reg;
    assign out_vert  = vert_reg;
    assign out_last  = last_reg;

    // split the current tetrahedron into inside and outside lists
    always_comb
    begin
        logic [2:0] cc;
        ni     = '0;
        no     = '0;
        ins_l  = '0;
        outs_l = '0;
        for (int i = 0; i < 4; i++)
        begin
            cc = tet_corner(tet_reg, 2'(i));
            if (head.ins[cc])
            begin
                ins_l[ni[1:0]] = cc;
                ni = ni + 1'b1;
            end
            else
            begin
                outs_l[no[1:0]] = cc;
                no = no + 1'b1;
            end
        end
    end

    always_comb
    begin
        logic [3:0] b;
        later_act = 1'b0;
        for (int t = 0; t < 6; t++)
        begin
            for (int i = 0; i < 4; i++)
            begin
                b[i] = head.ins[tet_corner(3'(t), 2'(i))];
            end
            act[t] = (|b) && !(&b);
            if (act[t] && (3'(t) > tet_reg))
                later_act = 1'b1;
        end
    end

    // edge endpoints for the three vertex slots
    always_comb
    begin
        case (ni)
            3'd1:
            begin
                p_idx = {ins_l[0], ins_l[0], ins_l[0]};
                q_idx = {outs_l[2], outs_l[1], outs_l[0]};
            end
            3'd3:
            begin
                p_idx = {outs_l[0], outs_l[0], outs_l[0]};
                q_idx = {ins_l[1], ins_l[2], ins_l[0]};
            end
            default:
            begin
                if (!tri_reg)
                begin
                    p_idx = {ins_l[1], ins_l[0], ins_l[0]};
                    q_idx = {outs_l[0], outs_l[1], outs_l[0]};
                end
                else
                begin
                    p_idx = {ins_l[1], ins_l[1], ins_l[0]};
                    q_idx = {outs_l[0], outs_l[1], outs_l[1]};
                end
            end
        endcase
        for (int s = 0; s < 3; s++)
        begin
            for (int ax = 0; ax < 3; ax++)
            begin
                req[s].p_pos[ax] = corner_bit(p_idx[s], 2'(ax)) ? head.pos_hi[ax]
                                                                 : head.pos_lo[ax];
                req[s].q_pos[ax] = corner_bit(q_idx[s], 2'(ax)) ? head.pos_hi[ax]
                                                                 : head.pos_lo[ax];
            end
            req[s].va = head.val[p_idx[s]];
            req[s].vb = head.val[q_idx[s]];
        end
    end

    assign skip    = (state_reg == B_TET) && ((ni == 3'd0) || (ni == 3'd4));
    assign start   = (state_reg == B_TET) && !skip;
    assign load    = (state_reg == B_WAIT) && (busy == '0) && (!out_valid_reg || out_ready);
    assign tet_end = skip || (load && ((ni != 3'd2) || tri_reg));
    assign pop     = tet_end && (tet_reg == 3'd5);

    for (genvar s = 0; s < 3; s++)
    begin : g_edge
        mtc_edge u_edge (
            .clk   (clk),
            .rst_n (rst_n),
            .start (start),
            .iso   (iso),
            .req   (req[s]),
            .busy  (busy[s]),
            .pt    (pt[s])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            tet_reg       <= '0;
            tri_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                B_IDLE:
                begin
                    tet_reg <= '0;
                    tri_reg <= 1'b0;
                    if (!empty)
                        state_reg <= B_TET;
                end
                B_TET:
                begin
                    if (start)
                        state_reg <= B_WAIT;
                    else if (tet_reg == 3'd5)
                        state_reg <= B_IDLE;
                    else
                        tet_reg <= tet_reg + 1'b1;
                end
                B_WAIT:
                begin
                    if (load)
                    begin
                        if ((ni == 3'd2) && !tri_reg)
                        begin
                            tri_reg   <= 1'b1;
                            state_reg <= B_TET;
                        end
                        else
                        begin
                            tri_reg   <= 1'b0;
                            state_reg <= (tet_reg == 3'd5) ? B_IDLE : B_TET;
                            tet_reg   <= tet_reg + 1'b1;
                        end
                    end
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            vert_reg <= pt;
            last_reg <= ((ni != 3'd2) || tri_reg) && !later_act;
        end
    end

`ifndef SYNTHESIS
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (!out_valid_reg || out_ready))
        else $error("triangle loaded over an untaken word");
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> (busy == '0))
        else $error("edge units started while busy");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> (out_valid_reg && $stable(vert_reg)))
        else $error("waiting triangle word dropped or changed");
`endif

endmodule

[rtl/marching_tetrahedra_cube_top.sv]
// ----------------------------------------------------------------------------
// marching_tetrahedra_cube_top
// Marching tetrahedra surface extraction, one grid cube per input word.
// ----------------------------------------------------------------------------
// Each input word is one cube: grid indices and eight Q4.12 corner densities.
// The front takes a word every cycle while its two-entry cube queue has room;
// cubes that lie off the grid or are wholly inside or outside are dropped
// there at once. The back splits each queued cube into six tetrahedra and
// sends one output word per triangle, tlast on the cube's final triangle.
// Three mtc_edge units run the three vertices of a triangle in parallel,
// each with a multiplier and a 16-step restoring divider per axis; a vertex
// that clamps to a corner of its edge needs neither. A tetrahedron that the
// surface misses is skipped, output stalls hold the back, and the back ends
// one cube before it pops the next. Write configuration only while idle.
// ----------------------------------------------------------------------------
module marching_tetrahedra_cube_top (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration: 0 iso_level, 1 origin_offset, 2 cell_step
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mtc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mtc_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // cube_x, cube_y, cube_z, corner_value_0 .. corner_value_7
    input  logic [151:0]                      s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // vert_a_x, vert_a_y, vert_a_z, vert_b_x .. vert_b_z, vert_c_x .. vert_c_z
    output logic [143:0]                      m_axis_tdata,
    // last_of_cube
    output logic                              m_axis_tlast
);
    import mtc_pkg::*;

    cfg_t               cfg_reg;
    logic [2:0][7:0]    in_idx;
    dens_t [7:0]        in_val;
    logic               push;
    cube_t              push_data;
    logic               pop;
    cube_t              head;
    logic               full;
    logic               empty;
    coord_t [2:0][2:0]  out_vert;

    // registers take a write in any cycle
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.iso    <= 16'd2253;
            cfg_reg.origin <= -15'sd7936;
            cfg_reg.step   <= 14'd512;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_ISO:    cfg_reg.iso    <= cfg_data;
                REG_ORIGIN: cfg_reg.origin <= cfg_data[14:0];
                REG_STEP:   cfg_reg.step   <= cfg_data[13:0];
                default:    ;
            endcase
        end
    end

    // unpack the input word
    always_comb
    begin
        for (int ax = 0; ax < 3; ax++)
        begin
            in_idx[ax] = s_axis_tdata[8*ax +: 8];
        end
        for (int v = 0; v < 8; v++)
        begin
            in_val[v] = s_axis_tdata[24 + 16*v +: 16];
        end
    end

    mtc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_idx    (in_idx),
        .in_val    (in_val),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    mtc_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .full      (full),
        .empty     (empty)
    );

    mtc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .iso       (cfg_reg.iso),
        .head      (head),
        .empty     (empty),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_vert  (out_vert),
        .out_last  (m_axis_tlast)
    );

    // pack vertices a, b, c, each x, y, z, lowest first
    always_comb
    begin
        for (int s = 0; s < 3; s++)
        begin
            for (int ax = 0; ax < 3; ax++)
            begin
                m_axis_tdata[16*(3*s + ax) +: 16] = out_vert[s][ax];
            end
        end
    end

endmodule

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench of the marching tetrahedra cube block.
// ----------------------------------------------------------------------------
// Cube words are driven on the input stream and every triangle word that
// comes out is checked against a behavioural triangle generator held here.
// Directed cubes cover the field extremes, each tetrahedron case and the
// off-grid and empty cubes; random cubes follow under several register
// settings, with random gaps and stalls and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;
    import mtc_pkg::*;

    typedef struct {
        logic [15:0] vx [9];
        logic        last;
    } tri_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [1:0]   cfg_index = '0;
    logic [15:0]  cfg_data = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [151:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [143:0] m_axis_tdata;
    logic         m_axis_tlast;

    // behavioural copy of the registers
    int unsigned  iso_q = 2253;
    int           org_q = -7936;
    int unsigned  step_q = 512;

    tri_t         tri_q [$];
    int           errors = 0;
    int           tri_seen = 0;
    int           cubes_sent = 0;
    bit           calm = 1'b0;     // no idling on either side
    int           hold_cycles = 0; // long hold-off on the output side
    int           pos_t [8][3];
    int           val_t [8];

    marching_tetrahedra_cube_top DUT (.*);

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Triangle generator
    // ------------------------------------------------------------------
    function automatic int sat16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return int'(v);
    endfunction

    function automatic void edge_pt(int p, int q, output int r [3]);
        longint num, den, prod, qv, pa, pb;
        num = longint'(iso_q) - val_t[p];
        den = longint'(val_t[q]) - val_t[p];
        if (den < 0)
        begin
            den = -den;
            num = -num;
        end
        for (int ax = 0; ax < 3; ax++)
        begin
            pa = pos_t[p][ax];
            pb = pos_t[q][ax];
            if (den == 0) r[ax] = (num > 0) ? pb : pa;
            else if (num <= 0) r[ax] = pa;
            else if (num >= den) r[ax] = pb;
            else
            begin
                prod = (pb - pa) * num;
                if (prod >= 0) qv = (2 * prod + den) / (2 * den);
                else qv = -((2 * (-prod) + den) / (2 * den));
                r[ax] = int'(pa + qv);
            end
        end
    endfunction

    function automatic void push_tri(int a [3], int b [3], int c [3]);
        tri_t t;
        for (int ax = 0; ax < 3; ax++)
        begin
            t.vx[ax]     = a[ax][15:0];
            t.vx[3 + ax] = b[ax][15:0];
            t.vx[6 + ax] = c[ax][15:0];
        end
        t.last = 1'b0;
        tri_q.push_back(t);
    endfunction

    function automatic void predict_cube(logic [7:0] cx, logic [7:0] cy, logic [7:0] cz,
                                         logic [15:0] cv [8]);
        int tet [6][4] = '{'{0, 5, 1, 6}, '{0, 5, 6, 4}, '{0, 1, 2, 6},
                           '{0, 2, 3, 6}, '{0, 3, 7, 6}, '{0, 7, 4, 6}};
        int offs [8][3] = '{'{0, 0, 0}, '{1, 0, 0}, '{1, 1, 0}, '{0, 1, 0},
                            '{0, 0, 1}, '{1, 0, 1}, '{1, 1, 1}, '{0, 1, 1}};
        int base [3];
        int ins [4], outs [4];
        int a [3], b [3], c [3], d [3];
        int ni, no, n_in, first, apex;
        base = '{cx, cy, cz};
        if (cx > GRID_DIM - 2 || cy > GRID_DIM - 2 || cz > GRID_DIM - 2) return;
        n_in = 0;
        for (int v = 0; v < 8; v++)
        begin
            val_t[v] = cv[v];
            if (cv[v] >= iso_q) n_in++;
            for (int ax = 0; ax < 3; ax++)
                pos_t[v][ax] = sat16(longint'(org_q) +
                                     longint'(base[ax] + offs[v][ax]) * step_q);
        end
        if (n_in == 0 || n_in == 8) return;
        first = tri_q.size();
        for (int t = 0; t < 6; t++)
        begin
            ni = 0;
            no = 0;
            for (int i = 0; i < 4; i++)
                if (val_t[tet[t][i]] >= iso_q) ins[ni++] = tet[t][i];
                else outs[no++] = tet[t][i];
            if (ni == 1)
            begin
                apex = ins[0];
                edge_pt(apex, outs[0], a);
                edge_pt(apex, outs[1], b);
                edge_pt(apex, outs[2], c);
                push_tri(a, b, c);
            end
            else if (ni == 3)
            begin
                // winding flips when the apex is the outside corner
                apex = outs[0];
                edge_pt(apex, ins[0], a);
                edge_pt(apex, ins[1], b);
                edge_pt(apex, ins[2], c);
                push_tri(a, c, b);
            end
            else if (ni == 2)
            begin
                edge_pt(ins[0], outs[0], a);
                edge_pt(ins[0], outs[1], b);
                edge_pt(ins[1], outs[0], c);
                edge_pt(ins[1], outs[1], d);
                push_tri(a, b, c);
                push_tri(b, d, c);
            end
        end
        if (tri_q.size() > first) tri_q[$].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    // hold tvalid high across back-to-back words; drop it only while idling
    task automatic send_cube(logic [7:0] cx, logic [7:0] cy, logic [7:0] cz,
                             logic [15:0] cv [8]);
        logic [151:0] w;
        while (!calm && $urandom_range(99) < 27)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        w = {cv[7], cv[6], cv[5], cv[4], cv[3], cv[2], cv[1], cv[0], cz, cy, cx};
        predict_cube(cx, cy, cz, cv);
        s_axis_tdata  <= w;
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        cubes_sent++;
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_ISO:    iso_q = data;
            REG_ORIGIN: org_q = $signed(data[14:0]);
            REG_STEP:   step_q = data[13:0];
            default:    ;
        endcase
    endtask

    // drain, then let the back finish any cube that makes no triangle
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (tri_q.size() != 0) @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic rand_cube(int mode);
        logic [15:0] cv [8];
        logic [7:0]  cx, cy, cz;
        cx = $urandom_range(15) == 0 ? 8'($urandom) : 8'($urandom_range(254));
        cy = $urandom_range(15) == 0 ? 8'($urandom) : 8'($urandom_range(254));
        cz = $urandom_range(15) == 0 ? 8'($urandom) : 8'($urandom_range(254));
        for (int v = 0; v < 8; v++)
            // mostly straddle the level so triangles come out
            if (mode == 0 && $urandom_range(3) != 0)
                cv[v] = $urandom_range(1) ? 16'(iso_q + $urandom_range(3000))
                                          : 16'(int'(iso_q) - int'($urandom_range(3000)));
            else
                cv[v] = 16'($urandom);
        send_cube(cx, cy, cz, cv);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        logic [15:0] cv [8];
        // every single-corner pattern, then its complement
        for (int k = 0; k < 8; k++)
        begin
            foreach (cv[v]) cv[v] = (v == k) ? 16'hFFFF : 16'h0000;
            send_cube(8'd0, 8'd0, 8'd0, cv);
            foreach (cv[v]) cv[v] = (v == k) ? 16'h0000 : 16'd4000;
            send_cube(8'd254, 8'd254, 8'd254, cv);
        end
        // two inside corners, and a value exactly on the level
        cv = '{2253, 2253, 0, 0, 0, 0, 100, 0};
        send_cube(8'd10, 8'd200, 8'd77, cv);
        cv = '{5000, 0, 5000, 0, 5000, 0, 5000, 0};
        send_cube(8'd128, 8'd1, 8'd255, cv);
        // off the grid and wholly inside / outside
        cv = '{9999, 0, 0, 0, 0, 0, 0, 0};
        send_cube(8'd255, 8'd3, 8'd3, cv);
        send_cube(8'd3, 8'd255, 8'd3, cv);
        foreach (cv[v]) cv[v] = 16'hFFFF;
        send_cube(8'd1, 8'd2, 8'd3, cv);
        foreach (cv[v]) cv[v] = 16'h0000;
        send_cube(8'd1, 8'd2, 8'd3, cv);
        cv = '{16'hAAAA, 16'h5555, 1, 16'h8000, 16'h7FFF, 0, 16'hFFFE, 2252};
        send_cube(8'hAA, 8'h55, 8'h01, cv);
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++) rand_cube(i % 5 == 4);
    endtask

    task automatic test_backpressure();
        // hold the output for a long stretch while cubes keep coming
        hold_cycles = 600;
        calm = 1'b1;
        for (int i = 0; i < 8; i++) rand_cube(0);
        calm = 1'b0;
    endtask

    task automatic test_settings();
        // extremes: zero level, lowest origin and zero step, then the highest level and origin
        settle();
        write_reg(REG_ISO, 16'd0);
        write_reg(REG_ORIGIN, 16'h4000);
        write_reg(REG_STEP, 16'd0);
        test_random(8);
        settle();
        write_reg(REG_ISO, 16'hFFFF);
        write_reg(REG_ORIGIN, 16'h3FFF);
        write_reg(REG_STEP, 16'd8192);
        test_random(8);
        settle();
        write_reg(REG_ISO, 16'd30000);
        write_reg(REG_ORIGIN, 16'h4000);
        write_reg(REG_STEP, 16'd8192);
        test_random(15);
        settle();
        write_reg(REG_ISO, 16'd1000);
        write_reg(REG_ORIGIN, 16'h0123);
        write_reg(REG_STEP, 16'd77);
        test_random(15);
    endtask

    // ------------------------------------------------------------------
    // Output side: random stalls, long hold-off on request
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles   <= hold_cycles - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= calm || ($urandom_range(99) >= 27);
    end

    // check each triangle word against the oldest predicted one
    always @(posedge clk)
    begin
        tri_t e;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            tri_seen++;
            if (tri_q.size() == 0)
            begin
                $error("triangle word with none predicted");
                errors++;
            end
            else
            begin
                e = tri_q.pop_front();
                for (int f = 0; f < 9; f++)
                    if (m_axis_tdata[16*f +: 16] !== e.vx[f])
                    begin
                        $error("vertex field %0d: expected %0d actual %0d", f,
                               $signed(e.vx[f]), $signed(m_axis_tdata[16*f +: 16]));
                        errors++;
                    end
                if (m_axis_tlast !== e.last)
                begin
                    $error("last_of_cube: expected %0b actual %0b", e.last, m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #20_000_000;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        test_directed();
        test_backpressure();
        calm = 1'b1;
        test_random(20);
        calm = 1'b0;
        test_random(30);
        test_settings();
        s_axis_tvalid <= 1'b0;
        while (tri_q.size() != 0) @(posedge clk);
        repeat (300) @(posedge clk);
        if (tri_q.size() != 0) errors++;
        $display("covered %0d cubes and %0d triangles under five register settings",
                 cubes_sent, tri_seen);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
